// ----- rtl/fipm_pkg.sv -----
package fipm_pkg;

	// offset counter and stored offset width
	localparam int unsigned OFF_W = 9;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;

	// key is real_ip in the high half, mark in the low half
	localparam int unsigned KEY_W = 64;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 8'd1;

	// result status codes
	typedef enum logic [1:0] {
		ST_HIT       = 2'd0,
		ST_NEW       = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_RULE_FAIL = 2'd3
	} status_t;

	// search token passed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic             hit;
		logic [OFF_W-1:0] off;
	} token_t;

	// write port shared by all cells
	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] off;
	} entry_wr_t;

endpackage

// ----- rtl/fipm_cell.sv -----
module fipm_cell #(
	parameter int IDX = 0,
	parameter int FW  = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  logic [FW-1:0]      fill_count,
	input  fipm_pkg::entry_wr_t wr,
	input  fipm_pkg::token_t   tok_in,
	output fipm_pkg::token_t   tok_out
);

	logic [fipm_pkg::KEY_W-1:0] key_q;
	logic [fipm_pkg::OFF_W-1:0] off_q;
	logic                       tok_valid_q;
	logic [fipm_pkg::KEY_W-1:0] tok_key_q;
	logic                       tok_hit_q;
	logic [fipm_pkg::OFF_W-1:0] tok_off_q;
	logic                       in_use;
	logic                       match;

	// this entry holds a key once the fill count has passed it
	assign in_use = FW'(IDX) < fill_count;
	assign match  = tok_in.valid && in_use && (key_q == tok_in.key);

	// entry storage, written at the slot the fill count points to
	always_ff @(posedge clk) begin
		if (wr.en && (fill_count == FW'(IDX))) begin
			key_q <= wr.key;
			off_q <= wr.off;
		end
	end

	// token stage: compare and hand on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (shift_en) begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			tok_key_q <= tok_in.key;
			tok_hit_q <= tok_in.hit || match;
			tok_off_q <= tok_in.hit ? tok_in.off : off_q;
		end
	end

	assign tok_out = '{valid: tok_valid_q, key: tok_key_q, hit: tok_hit_q, off: tok_off_q};

endmodule

// ----- rtl/fake_ipv4_map_allocator.sv -----
// An accepted request's search token is registered in turn by each of the ENTRIES
// cells, one cell per cycle while the row is not stalled, and its decision at the end
// loads the output register behind m_tvalid; one request in flight at a time.
// A result waiting on m_tready does not block the next request from being accepted.
// Reset (arst_n, async, active low) empties the table and clears the offset counter;
// pool_base resets to 0 and pool_limit to 256, no clearing pass is needed.
module fake_ipv4_map_allocator #(
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// fields from bit 0: real_ip[31:0], mark[63:32], rule_ok[64], zero pad
	input  logic [71:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fields from bit 0: status[1:0], fake_ip[33:2], zero pad
	output logic [39:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fipm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data
);

	localparam int FW = $clog2(ENTRIES + 1);

	logic [31:0]                pool_base_q;
	logic [fipm_pkg::OFF_W-1:0] pool_limit_q;
	logic [FW-1:0]              fill_count_q;
	logic [fipm_pkg::OFF_W-1:0] next_offset_q;
	logic                       busy_q;
	logic                       rule_ok_q;
	logic                       m_tvalid_q;
	fipm_pkg::status_t          status_q;
	logic [31:0]                fake_ip_q;

	fipm_pkg::token_t           tok [0:ENTRIES];
	fipm_pkg::token_t           tail;
	fipm_pkg::entry_wr_t        wr;
	logic                       accept;
	logic                       shift_en;
	logic                       decide;
	logic [fipm_pkg::OFF_W:0]   candidate;
	logic                       advance;
	logic                       exhausted;
	logic                       table_full;
	fipm_pkg::status_t          status_d;
	logic [31:0]                fake_ip_d;

	// input side
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign tok[0].valid = accept;
	assign tok[0].key   = {s_tdata[31:0], s_tdata[63:32]};
	assign tok[0].hit   = 1'b0;
	assign tok[0].off   = '0;

	// the row stalls only while a finished token waits for the output register
	assign tail     = tok[ENTRIES];
	assign shift_en = !(tail.valid && m_tvalid_q && !m_tready);
	assign decide   = tail.valid && shift_en;

	// cell row
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		fipm_cell #(
			.IDX (i),
			.FW  (FW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (shift_en),
			.fill_count (fill_count_q),
			.wr         (wr),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

	// allocation decision at the end of the row
	assign candidate  = {1'b0, next_offset_q} + 1'b1;
	assign advance    = (next_offset_q <= pool_limit_q) && (next_offset_q != fipm_pkg::OFF_MAX);
	assign exhausted  = candidate > {1'b0, pool_limit_q};
	assign table_full = fill_count_q == FW'(ENTRIES);

	always_comb begin
		status_d  = fipm_pkg::ST_NEW;
		fake_ip_d = pool_base_q + {{(32 - fipm_pkg::OFF_W){1'b0}},
			candidate[fipm_pkg::OFF_W-1:0]};
		if (tail.hit) begin
			status_d  = fipm_pkg::ST_HIT;
			fake_ip_d = pool_base_q + {{(32 - fipm_pkg::OFF_W){1'b0}}, tail.off};
		end else if (exhausted || table_full) begin
			status_d  = fipm_pkg::ST_EXHAUSTED;
			fake_ip_d = '0;
		end else if (!rule_ok_q) begin
			status_d  = fipm_pkg::ST_RULE_FAIL;
			fake_ip_d = '0;
		end
	end

	assign wr.en  = decide && (status_d == fipm_pkg::ST_NEW);
	assign wr.key = tail.key;
	assign wr.off = candidate[fipm_pkg::OFF_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_limit_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fipm_pkg::CFG_POOL_BASE:  pool_base_q  <= cfg_data;
				fipm_pkg::CFG_POOL_LIMIT: pool_limit_q <= cfg_data[fipm_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// table fill and offset counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q  <= '0;
			next_offset_q <= '0;
		end else begin
			if (wr.en) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
			if (decide && !tail.hit && advance) begin
				next_offset_q <= candidate[fipm_pkg::OFF_W-1:0];
			end
		end
	end

	// request tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (decide) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rule_ok_q <= s_tdata[64];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (decide) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide) begin
			status_q  <= status_d;
			fake_ip_q <= fake_ip_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, fake_ip_q, status_q};

`ifndef SYNTHESIS
	a_decide_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		decide |=> m_tvalid_q)
		else $error("decision did not load the output register");

	a_fill_steps_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> fill_count_q == $past(fill_count_q) + 1'b1)
		else $error("fill count did not advance on a new entry");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FW'(ENTRIES))
		else $error("fill count beyond table size");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted request not tracked");

	a_tail_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("search token without a request in flight");
`endif

endmodule
